/* rtl/core/modbus_rtu_single_register_framer_top_assert.svh */
// Assertion macros used by the Modbus RTU framer top level.
`ifndef MODBUS_RTU_SINGLE_REGISTER_FRAMER_TOP_ASSERT_SVH
`define MODBUS_RTU_SINGLE_REGISTER_FRAMER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBRTU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MBRTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mbrtu_pkg.sv */
// Types, constants and the CRC step shared by the Modbus RTU framer modules.
package mbrtu_pkg;

    localparam int DATA_W = 56;

    localparam logic [7:0]  FC_READ       = 8'h03;
    localparam logic [7:0]  FC_WRITE      = 8'h06;
    localparam logic [15:0] READ_REG_MARK = 16'hFFFF;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    // Index of the final response byte for each expected reply.
    localparam logic [2:0] RX_LAST_WRITE = 3'd7;
    localparam logic [2:0] RX_LAST_READ  = 3'd6;

    // Transmit byte positions.
    localparam logic [2:0] TX_CRC_LO = 3'd6;
    localparam logic [2:0] TX_LAST   = 3'd7;

    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    typedef enum logic {
        MODE_SEND = 1'b0,
        MODE_RECV = 1'b1
    } t_mode;

    typedef enum logic {
        KIND_TX   = 1'b0,
        KIND_RESP = 1'b1
    } t_kind;

    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_FRAME = 1'b1
    } t_back_state;

    // One queued job: a request to transmit, or a parsed response to report.
    // flag is the write bit for a request and the ok bit for a response.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  slave;
        logic [15:0] addr_field;
        logic [15:0] val_field;
        logic        flag;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // One byte of CRC-16/Modbus, reflected polynomial.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/core/mbrtu_front.sv */
// Front end: accepts input transactions, tracks the response parser and queues jobs.
module mbrtu_front
    import mbrtu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_slave_address,
    input  logic        i_function_code,
    input  logic [15:0] i_register_address,
    input  logic [15:0] i_value,
    input  logic [7:0]  i_rx_byte,
    input  t_q_status   i_q_stat,
    output logic        o_push,
    output t_job        o_push_job
);

    logic        r_expected_write, n_expected_write;
    logic [2:0]  r_rx_count, n_rx_count;
    logic [15:0] r_rx_crc, n_rx_crc;
    logic [7:0]  r_rx_slave, n_rx_slave;
    logic [7:0]  r_rx_function, n_rx_function;
    logic [15:0] r_rx_register, n_rx_register;
    logic [15:0] r_rx_value, n_rx_value;
    logic [7:0]  r_rx_check_lo, n_rx_check_lo;

    logic        accept;
    t_mode       mode;
    logic [2:0]  last_idx;
    logic        resp_ok;

    assign mode     = t_mode'(i_mode);
    assign o_ready  = !i_q_stat.full;
    assign accept   = i_valid && !i_q_stat.full;
    assign last_idx = r_expected_write ? RX_LAST_WRITE : RX_LAST_READ;

    // On the final byte only the high byte of the received CRC is new.
    assign resp_ok = (r_rx_function == (r_expected_write ? FC_WRITE : FC_READ)) &&
                     ({i_rx_byte, r_rx_check_lo} == r_rx_crc);

    always_comb begin
        n_expected_write = r_expected_write;
        n_rx_count       = r_rx_count;
        n_rx_crc         = r_rx_crc;
        n_rx_slave       = r_rx_slave;
        n_rx_function    = r_rx_function;
        n_rx_register    = r_rx_register;
        n_rx_value       = r_rx_value;
        n_rx_check_lo    = r_rx_check_lo;
        o_push           = 1'b0;
        o_push_job       = '0;

        if (accept) begin
            if (mode == MODE_SEND) begin
                o_push                = 1'b1;
                o_push_job.kind       = KIND_TX;
                o_push_job.slave      = i_slave_address;
                o_push_job.addr_field = i_register_address;
                o_push_job.val_field  = i_value;
                o_push_job.flag       = i_function_code;
                n_expected_write      = i_function_code;
                n_rx_count            = 3'd0;
                n_rx_crc              = CRC_INIT;
            end else begin
                if (r_rx_count < last_idx - 3'd1) begin
                    n_rx_crc = crc_byte(r_rx_crc, i_rx_byte);
                end

                if (r_rx_count == 3'd0) begin
                    n_rx_slave = i_rx_byte;
                end else if (r_rx_count == 3'd1) begin
                    n_rx_function = i_rx_byte;
                end else if (r_expected_write) begin
                    unique case (r_rx_count)
                        3'd2:    n_rx_register[15:8] = i_rx_byte;
                        3'd3:    n_rx_register[7:0]  = i_rx_byte;
                        3'd4:    n_rx_value[15:8]    = i_rx_byte;
                        3'd5:    n_rx_value[7:0]     = i_rx_byte;
                        3'd6:    n_rx_check_lo       = i_rx_byte;
                        default: ;
                    endcase
                end else begin
                    unique case (r_rx_count)
                        3'd3:    n_rx_value[15:8] = i_rx_byte;
                        3'd4:    n_rx_value[7:0]  = i_rx_byte;
                        3'd5:    n_rx_check_lo    = i_rx_byte;
                        default: ;
                    endcase
                end

                if (r_rx_count == last_idx) begin
                    o_push                = 1'b1;
                    o_push_job.kind       = KIND_RESP;
                    o_push_job.slave      = r_rx_slave;
                    o_push_job.addr_field = r_expected_write ? r_rx_register : READ_REG_MARK;
                    o_push_job.val_field  = r_rx_value;
                    o_push_job.flag       = resp_ok;
                    n_rx_count            = 3'd0;
                    n_rx_crc              = CRC_INIT;
                end else begin
                    n_rx_count = r_rx_count + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_write <= 1'b0;
            r_rx_count       <= 3'd0;
            r_rx_crc         <= CRC_INIT;
        end else begin
            r_expected_write <= n_expected_write;
            r_rx_count       <= n_rx_count;
            r_rx_crc         <= n_rx_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx_slave    <= n_rx_slave;
        r_rx_function <= n_rx_function;
        r_rx_register <= n_rx_register;
        r_rx_value    <= n_rx_value;
        r_rx_check_lo <= n_rx_check_lo;
    end

endmodule

/* rtl/core/mbrtu_queue.sv */
// Two-entry shifting job queue between the front end and the back end.
module mbrtu_queue
    import mbrtu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_push_job,
    input  logic      i_pop,
    output t_q_status o_stat,
    output t_job      o_head
);

    logic [1:0] r_count, n_count;
    t_job       r_slot0, n_slot0;
    t_job       r_slot1, n_slot1;
    logic [1:0] wr_idx;

    assign o_stat.full  = (r_count == QUEUE_DEPTH);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_head       = r_slot0;
    assign wr_idx       = r_count - {1'b0, i_pop};

    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (i_pop) begin
            n_slot0 = r_slot1;
        end
        if (i_push) begin
            if (wr_idx == 2'd0) begin
                n_slot0 = i_push_job;
            end else begin
                n_slot1 = i_push_job;
            end
        end
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

/* rtl/core/mbrtu_back.sv */
// Back end: serialises request frames with their CRC, passes parsed responses on and drives the output register.
module mbrtu_back
    import mbrtu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_q_status         i_q_stat,
    input  t_job              i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic              o_last,
    output logic [DATA_W-1:0] o_data
);

    t_back_state       r_state, n_state;
    t_job              r_job, n_job;
    logic [2:0]        r_idx, n_idx;
    logic [15:0]       r_crc, n_crc;
    logic              r_out_valid, n_out_valid;
    t_kind             r_out_kind, n_out_kind;
    logic              r_out_last, n_out_last;
    logic [DATA_W-1:0] r_out_data, n_out_data;

    logic              load;
    logic              framing;
    t_job              cur_job;
    logic [2:0]        cur_idx;
    logic [15:0]       cur_crc;
    logic [7:0]        tx_byte;

    assign load    = !r_out_valid || i_ready;
    assign framing = (r_state == BK_FRAME);
    assign cur_job = framing ? r_job : i_head;
    assign cur_idx = framing ? r_idx : 3'd0;
    assign cur_crc = framing ? r_crc : CRC_INIT;

    always_comb begin
        unique case (cur_idx)
            3'd0:    tx_byte = cur_job.slave;
            3'd1:    tx_byte = cur_job.flag ? FC_WRITE : FC_READ;
            3'd2:    tx_byte = cur_job.addr_field[15:8];
            3'd3:    tx_byte = cur_job.addr_field[7:0];
            3'd4:    tx_byte = cur_job.val_field[15:8];
            3'd5:    tx_byte = cur_job.val_field[7:0];
            3'd6:    tx_byte = cur_crc[7:0];
            default: tx_byte = cur_crc[15:8];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;

        if (load) begin
            n_out_valid = 1'b0;
            if (framing || !i_q_stat.empty) begin
                o_pop = !framing;
                n_job = cur_job;
                if (!framing && (i_head.kind == KIND_RESP)) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_RESP;
                    n_out_last  = 1'b0;
                    n_out_data  = {7'b0, i_head.flag, i_head.val_field,
                                   i_head.addr_field, i_head.slave, 8'h00};
                end else begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_TX;
                    n_out_last  = (cur_idx == TX_LAST);
                    n_out_data  = {48'b0, tx_byte};
                    n_crc       = (cur_idx < TX_CRC_LO) ? crc_byte(cur_crc, tx_byte) : cur_crc;
                    n_idx       = cur_idx + 3'd1;
                    n_state     = (cur_idx == TX_LAST) ? BK_IDLE : BK_FRAME;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_idx      <= n_idx;
        r_crc      <= n_crc;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
        r_out_data <= n_out_data;
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_last  = r_out_last;
    assign o_data  = r_out_data;

endmodule

/* rtl/core/modbus_rtu_single_register_framer_top.sv */
// Top level of the Modbus RTU single-register request framer and response parser.
//
// Input stream (s side): each transaction is either a request (tuser = 0) carrying the
// slave address, function (read 03 or write 06), register address and value, or one
// received response byte (tuser = 1). Output stream (m side): a request becomes eight
// transmit-byte transactions (tuser = 0), the eighth flagged by tlast, ending with the
// CRC-16/Modbus low then high byte. A completed response (8 bytes after a write, 7 after
// a read) becomes one transaction (tuser = 1) with slave, register, value and ok.
// The front end parses received bytes and queues jobs in a two-entry queue; the back end
// serialises frames. An accepted item is written into the queue, and its first output is
// then loaded from the queue head into the output register, from which it can be taken.
// The back end sends a request one byte per cycle while tready is high, the CRC updated
// byte by byte; received bytes can arrive back to back while the input tready is high.
// A request restarts the response parser. A synchronous active-low reset empties the queue
// and the output register and makes the parser expect a read reply. If the receiver holds
// tready low, the output register holds its transaction, the queue fills and then the input
// tready falls; nothing is lost.
`include "modbus_rtu_single_register_framer_top_assert.svh"

module modbus_rtu_single_register_framer_top
    import mbrtu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // [7:0] slave_address, [8] function_code, [24:9] register_address,
    // [40:25] value, [48:41] rx_byte, [55:49] zero
    input  logic [DATA_W-1:0] i_s_tdata,
    // [0] mode
    input  logic              i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // [7:0] tx_byte, [15:8] resp_slave, [31:16] resp_register,
    // [47:32] resp_value, [48] ok, [55:49] zero
    output logic [DATA_W-1:0] o_m_tdata,
    // [0] kind
    output logic              o_m_tuser,
    output logic              o_m_tlast
);

    t_q_status w_q_stat;
    t_job      w_push_job;
    t_job      w_head;
    logic      w_push;
    logic      w_pop;
    logic      w_tx_mid_taken;
    logic      w_resp_valid;
    logic      w_resp_clean;

    // Front end: classifies each transaction, runs the response parser.
    mbrtu_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_s_tvalid),
        .o_ready            (o_s_tready),
        .i_mode             (i_s_tuser),
        .i_slave_address    (i_s_tdata[7:0]),
        .i_function_code    (i_s_tdata[8]),
        .i_register_address (i_s_tdata[24:9]),
        .i_value            (i_s_tdata[40:25]),
        .i_rx_byte          (i_s_tdata[48:41]),
        .i_q_stat           (w_q_stat),
        .o_push             (w_push),
        .o_push_job         (w_push_job)
    );

    // Queue decoupling the parser from the frame serialiser.
    mbrtu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .i_pop      (w_pop),
        .o_stat     (w_q_stat),
        .o_head     (w_head)
    );

    // Back end: emits transmit bytes and parsed responses through the output register.
    mbrtu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_kind   (o_m_tuser),
        .o_last   (o_m_tlast),
        .o_data   (o_m_tdata)
    );

    // A non-final transmit byte taken by the receiver, and a valid parsed response.
    assign w_tx_mid_taken = o_m_tvalid && i_m_tready && (o_m_tuser == KIND_TX) && !o_m_tlast;
    assign w_resp_valid   = o_m_tvalid && (o_m_tuser == KIND_RESP);
    assign w_resp_clean   = (o_m_tdata[7:0] == 8'h00) && !o_m_tlast;

    // A queue cannot be full and empty at once.
    `MBRTU_ASSERT_SAME(a_queue_state, i_clk, i_rst_n, w_q_stat.full, !w_q_stat.empty, "queue full")

    // Once a non-final transmit byte is taken, the next byte of the frame follows at once.
    `MBRTU_ASSERT_NEXT(a_frame_no_gap, i_clk, i_rst_n, w_tx_mid_taken, o_m_tvalid, "frame gap")

    // A parsed response carries no transmit byte and no frame end.
    `MBRTU_ASSERT_SAME(a_resp_clean, i_clk, i_rst_n, w_resp_valid, w_resp_clean, "dirty response")

endmodule
